// File: hw/rtl/three_wire_rtc_serial_master_assert.svh
// Assertion macros for the serial master checker.
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RTCSM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RTCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rtcsm_pkg.sv
// Types and constants of the three-wire serial clock chip master.
`timescale 1ns / 1ps
package rtcsm_pkg;

	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic CFG_HALF_BIT    = 1'b0;
	localparam logic CFG_ENABLE_WAIT = 1'b1;

	localparam logic [15:0] HALF_BIT_RESET    = 16'd16;
	localparam logic [15:0] ENABLE_WAIT_RESET = 16'd48;

	localparam logic [2:0] LAST_BIT = 3'd7;

	typedef enum logic [7:0] {
		PH_IDLE      = 8'b0000_0001,
		PH_SETUP     = 8'b0000_0010,
		PH_BIT_DATA  = 8'b0000_0100,
		PH_BIT_HIGH  = 8'b0000_1000,
		PH_BIT_LOW   = 8'b0001_0000,
		PH_READ_HIGH = 8'b0010_0000,
		PH_READ_LOW  = 8'b0100_0000,
		PH_HOLD      = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] command_byte;
		logic [7:0] write_byte;
		logic       io_in;
	} in_item_t;

	typedef struct packed {
		logic       chip_enable;
		logic       serial_clock;
		logic       io_out;
		logic       io_drive;
		logic [7:0] read_byte;
		logic       done_res;
		logic       busy_res;
	} out_item_t;

	typedef struct packed {
		logic [15:0] half_bit_ticks;
		logic [15:0] enable_wait_ticks;
	} cfg_t;

endpackage

// File: hw/rtl/rtcsm_if.sv
// Valid/ready channel interfaces for tick items and pin results.
`timescale 1ns / 1ps
interface rtcsm_in_if import rtcsm_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rtcsm_out_if import rtcsm_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rtcsm_cfg.sv
// Timing configuration registers of the serial master.
`timescale 1ns / 1ps
module rtcsm_cfg
	import rtcsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        we,
	input  logic        index,
	input  logic [15:0] wdata,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_bit_ticks    <= HALF_BIT_RESET;
			cfg_q.enable_wait_ticks <= ENABLE_WAIT_RESET;
		end else if (we) begin
			case (index)
				CFG_HALF_BIT:    cfg_q.half_bit_ticks    <= wdata;
				CFG_ENABLE_WAIT: cfg_q.enable_wait_ticks <= wdata;
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/rtcsm_seq.sv
// Pin sequencer: transaction state, advanced by one tick per step.
`timescale 1ns / 1ps
module rtcsm_seq
	import rtcsm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	phase_t      phase_q, phase_d;
	logic [2:0]  bit_q, bit_d;
	logic        byte_q, byte_d;
	logic        is_read_q, is_read_d;
	logic [7:0]  shift_out_q, shift_out_d;
	logic [7:0]  hold_q, hold_d;
	logic [7:0]  shift_in_q, shift_in_d;
	logic [15:0] wait_q, wait_d;
	logic        ce_q, ce_d;
	logic        sclk_q, sclk_d;
	logic        io_q, io_d;
	logic        drive_q, drive_d;
	logic        done;
	logic [2:0]  bit_inc;

	assign bit_inc = bit_q + 3'd1;

	always_comb begin
		phase_d     = phase_q;
		bit_d       = bit_q;
		byte_d      = byte_q;
		is_read_d   = is_read_q;
		shift_out_d = shift_out_q;
		hold_d      = hold_q;
		shift_in_d  = shift_in_q;
		wait_d      = wait_q;
		ce_d        = ce_q;
		sclk_d      = sclk_q;
		io_d        = io_q;
		drive_d     = drive_q;
		done        = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.cmd == CMD_WRITE || item.cmd == CMD_READ) begin
				is_read_d   = (item.cmd == CMD_READ);
				shift_out_d = {item.command_byte[7:1], item.cmd == CMD_READ};
				hold_d      = item.write_byte;
				bit_d       = 3'd0;
				byte_d      = 1'b0;
				sclk_d      = 1'b0;
				drive_d     = 1'b1;
				ce_d        = 1'b1;
				wait_d      = cfg.enable_wait_ticks;
				phase_d     = PH_SETUP;
			end
		end else if (wait_q > 16'd1) begin
			wait_d = wait_q - 16'd1;
		end else begin
			case (phase_q)
				PH_SETUP: begin
					io_d    = shift_out_q[bit_q];
					wait_d  = cfg.half_bit_ticks;
					phase_d = PH_BIT_DATA;
				end
				PH_BIT_DATA: begin
					sclk_d  = 1'b1;
					wait_d  = cfg.half_bit_ticks;
					phase_d = PH_BIT_HIGH;
				end
				PH_BIT_HIGH: begin
					wait_d = cfg.half_bit_ticks;
					if (is_read_q && !byte_q && bit_q == LAST_BIT) begin
						// turn the data pin around for the read byte
						drive_d = 1'b0;
						bit_d   = 3'd0;
						phase_d = PH_READ_HIGH;
					end else begin
						sclk_d  = 1'b0;
						phase_d = PH_BIT_LOW;
					end
				end
				PH_BIT_LOW: begin
					if (bit_q != LAST_BIT) begin
						bit_d   = bit_inc;
						io_d    = shift_out_q[bit_inc];
						wait_d  = cfg.half_bit_ticks;
						phase_d = PH_BIT_DATA;
					end else if (!byte_q && !is_read_q) begin
						byte_d      = 1'b1;
						shift_out_d = hold_q;
						bit_d       = 3'd0;
						io_d        = hold_q[0];
						wait_d      = cfg.half_bit_ticks;
						phase_d     = PH_BIT_DATA;
					end else begin
						ce_d    = 1'b0;
						wait_d  = cfg.enable_wait_ticks;
						phase_d = PH_HOLD;
					end
				end
				PH_READ_HIGH: begin
					sclk_d  = 1'b0;
					wait_d  = cfg.half_bit_ticks;
					phase_d = PH_READ_LOW;
				end
				PH_READ_LOW: begin
					shift_in_d[bit_q] = item.io_in;
					if (bit_q != LAST_BIT) begin
						bit_d   = bit_inc;
						sclk_d  = 1'b1;
						wait_d  = cfg.half_bit_ticks;
						phase_d = PH_READ_HIGH;
					end else begin
						ce_d    = 1'b0;
						wait_d  = cfg.enable_wait_ticks;
						phase_d = PH_HOLD;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					wait_d  = 16'd0;
					done    = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= 3'd0;
			byte_q      <= 1'b0;
			is_read_q   <= 1'b0;
			shift_out_q <= 8'd0;
			hold_q      <= 8'd0;
			shift_in_q  <= 8'd0;
			wait_q      <= 16'd0;
			ce_q        <= 1'b0;
			sclk_q      <= 1'b0;
			io_q        <= 1'b0;
			drive_q     <= 1'b1;
		end else if (step) begin
			phase_q     <= phase_d;
			bit_q       <= bit_d;
			byte_q      <= byte_d;
			is_read_q   <= is_read_d;
			shift_out_q <= shift_out_d;
			hold_q      <= hold_d;
			shift_in_q  <= shift_in_d;
			wait_q      <= wait_d;
			ce_q        <= ce_d;
			sclk_q      <= sclk_d;
			io_q        <= io_d;
			drive_q     <= drive_d;
		end
	end

	always_comb begin
		result.chip_enable  = ce_d;
		result.serial_clock = sclk_d;
		result.io_out       = io_d;
		result.io_drive     = drive_d;
		result.read_byte    = shift_in_d;
		result.done_res     = done;
		result.busy_res     = (phase_d != PH_IDLE);
	end

endmodule

// File: hw/rtl/three_wire_rtc_serial_master.sv
// Top level of the three-wire serial clock chip master.
`timescale 1ns / 1ps
// Each transaction on req is one tick of the pin sequencer and yields exactly one
// transaction on rsp with the pin levels, read byte and done/busy flags after that
// tick. A tick is accepted every clock cycle while req.ready is high; the item is held
// in the input register and its result is captured in the result register.
// The rate is set by the sequencer state update: one tick per cycle while not stalled.
// rsp backpressure stalls req only when both register stages are full. Configuration
// writes (index 0 half-bit ticks, index 1 enable wait ticks) are meant for idle periods.
module three_wire_rtc_serial_master
	import rtcsm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rtcsm_in_if.sink    req,
	rtcsm_out_if.source rsp,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result;
	out_item_t result_s2;
	logic      valid_s2;
	logic      advance;
	logic      step;

	rtcsm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	assign advance   = !valid_s2 || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	rtcsm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= result;
		end
	end

	assign rsp.valid = valid_s2;
	assign rsp.data  = result_s2;

endmodule

// File: hw/rtl/rtcsm_chk.sv
// Port-level checker for the serial master, bound to the top level.
`timescale 1ns / 1ps
`include "three_wire_rtc_serial_master_assert.svh"
module rtcsm_chk
	import rtcsm_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input out_item_t rsp_data
);

	`RTCSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")
	`RTCSM_ASSERT_NOW(a_done_not_busy, rsp_valid && rsp_data.done_res, !rsp_data.busy_res, "done while busy")
	`RTCSM_ASSERT_NOW(a_done_ce_low, rsp_valid && rsp_data.done_res, !rsp_data.chip_enable, "done with enable high")
	`RTCSM_ASSERT_NOW(a_idle_pins, rsp_valid && !rsp_data.busy_res, !rsp_data.chip_enable && !rsp_data.serial_clock, "idle with enable or clock high")

endmodule

bind three_wire_rtc_serial_master rtcsm_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
